// File: rtl/cfr_pkg.sv
package cfr_pkg;

  localparam logic [7:0] StartByte       = 8'h68;
  localparam logic [7:0] LengthLimit     = 8'd252;
  localparam logic [7:0] MaxCommandReset = 8'd5;

  typedef enum logic [2:0] {
    EV_PAYLOAD  = 3'd0,
    EV_ACCEPT   = 3'd1,
    EV_BAD_CMD  = 3'd2,
    EV_BAD_LEN  = 3'd3,
    EV_BAD_SUM  = 3'd4
  } event_t;

  typedef enum logic [5:0] {
    PH_HUNT = 6'b000001,
    PH_CMD  = 6'b000010,
    PH_LEN  = 6'b000100,
    PH_DATA = 6'b001000,
    PH_SUM  = 6'b010000,
    PH_TAIL = 6'b100000
  } phase_t;

  typedef struct packed {
    event_t     ev;
    logic [7:0] command;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] payload_length;
    logic [7:0] computed_sum;
  } result_t;

  // handshake between the core and the output register
  typedef struct packed {
    logic    valid;
    result_t res;
  } result_beat_t;

endpackage

// File: rtl/cfr_in_stage.sv
module cfr_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       held_valid,
  output logic [7:0] held_byte,
  input  logic       held_take
);

  assign rx_stall = held_valid && !held_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!rx_stall) begin
      held_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rx_stall && rx_valid) begin
      held_byte <= rx_byte;
    end
  end

endmodule

// File: rtl/cfr_core.sv
module cfr_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [7:0]            cfg_data,
  input  logic                  held_valid,
  input  logic [7:0]            held_byte,
  output logic                  held_take,
  input  logic                  out_ready,
  output cfr_pkg::result_beat_t beat
);

  cfr_pkg::phase_t phase, phase_next;
  logic [7:0] max_command;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] frame_command, frame_command_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] byte_index, byte_index_next;
  logic [7:0] sum_plus;
  logic [7:0] index_plus;
  logic       emit;
  cfr_pkg::result_t res;

  assign sum_plus   = running_sum + held_byte;
  assign index_plus = byte_index + 8'd1;

  always_comb begin
    phase_next         = phase;
    running_sum_next   = running_sum;
    frame_command_next = frame_command;
    frame_length_next  = frame_length;
    byte_index_next    = byte_index;
    emit               = 1'b0;
    res.ev             = cfr_pkg::EV_PAYLOAD;
    res.command        = frame_command;
    res.payload_byte   = 8'd0;
    res.payload_index  = 8'd0;
    res.payload_length = 8'd0;
    res.computed_sum   = running_sum;
    unique case (phase)
      cfr_pkg::PH_CMD: begin
        frame_command_next = held_byte;
        res.command        = held_byte;
        if (held_byte > max_command) begin
          emit       = 1'b1;
          res.ev     = cfr_pkg::EV_BAD_CMD;
          phase_next = cfr_pkg::PH_HUNT;
        end else begin
          running_sum_next = sum_plus;
          phase_next       = cfr_pkg::PH_LEN;
        end
      end
      cfr_pkg::PH_LEN: begin
        if (held_byte > cfr_pkg::LengthLimit) begin
          frame_length_next = 8'd0;
          emit              = 1'b1;
          res.ev            = cfr_pkg::EV_BAD_LEN;
          phase_next        = cfr_pkg::PH_HUNT;
        end else begin
          frame_length_next = held_byte;
          running_sum_next  = sum_plus;
          byte_index_next   = 8'd0;
          phase_next        = (held_byte == 8'd0) ? cfr_pkg::PH_SUM : cfr_pkg::PH_DATA;
        end
      end
      cfr_pkg::PH_DATA: begin
        running_sum_next   = sum_plus;
        emit               = 1'b1;
        res.ev             = cfr_pkg::EV_PAYLOAD;
        res.payload_byte   = held_byte;
        res.payload_index  = byte_index;
        res.payload_length = frame_length;
        res.computed_sum   = sum_plus;
        byte_index_next    = index_plus;
        if (index_plus >= frame_length) begin
          phase_next = cfr_pkg::PH_SUM;
        end
      end
      cfr_pkg::PH_SUM: begin
        emit               = 1'b1;
        res.payload_length = frame_length;
        if (held_byte == running_sum) begin
          res.ev     = cfr_pkg::EV_ACCEPT;
          phase_next = cfr_pkg::PH_TAIL;
        end else begin
          res.ev     = cfr_pkg::EV_BAD_SUM;
          phase_next = cfr_pkg::PH_HUNT;
        end
      end
      cfr_pkg::PH_TAIL: begin
        // trailer byte is swallowed without a check
        phase_next = cfr_pkg::PH_HUNT;
      end
      default: begin
        if (held_byte == cfr_pkg::StartByte) begin
          running_sum_next   = cfr_pkg::StartByte;
          frame_command_next = 8'd0;
          frame_length_next  = 8'd0;
          byte_index_next    = 8'd0;
          phase_next         = cfr_pkg::PH_CMD;
        end else begin
          phase_next = cfr_pkg::PH_HUNT;
        end
      end
    endcase
  end

  // bytes that produce no result never wait on the output side
  assign held_take  = held_valid && (!emit || out_ready);
  assign beat.valid = held_valid && emit && out_ready;
  assign beat.res   = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_command <= cfr_pkg::MaxCommandReset;
    end else if (cfg_write) begin
      max_command <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= cfr_pkg::PH_HUNT;
      running_sum   <= 8'd0;
      frame_command <= 8'd0;
      frame_length  <= 8'd0;
      byte_index    <= 8'd0;
    end else if (held_take) begin
      phase         <= phase_next;
      running_sum   <= running_sum_next;
      frame_command <= frame_command_next;
      frame_length  <= frame_length_next;
      byte_index    <= byte_index_next;
    end
  end

endmodule

// File: rtl/cfr_out_stage.sv
module cfr_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  cfr_pkg::result_beat_t beat,
  output logic                  out_ready,
  output logic                  res_valid,
  input  logic                  res_stall,
  output cfr_pkg::result_t      res
);

  assign out_ready = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_ready) begin
      res_valid <= beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (beat.valid) begin
      res <= beat.res;
    end
  end

endmodule

// File: rtl/checksum_frame_receiver_top.sv
// Frame receiver for a byte stream: hunts for start byte 0x68, then takes
// command, length, payload and a sum8 checksum byte, plus one trailer byte.
// Input channel: rx_valid / rx_stall / rx_byte, one received byte per beat.
// Result channel: res_valid / res_stall with event_res, command,
// payload_byte, payload_index, payload_length and computed_sum. A payload
// byte gives one result; a frame ends in one verdict (accepted, bad
// command, bad length, checksum mismatch). Other bytes give no result.
// Configuration: cfg_write / cfg_data set max_command (reset value 5);
// write only while the block is idle.
// Path: a byte waits in the input register and is then decoded into the
// result register, from which its result is presented.
// Throughput: one byte per cycle unless res_stall holds a result; the single
// decode stage between the input and result registers sets this figure.
// Stall: while res_stall holds a result, the result register keeps it; a
// byte that would give a result waits in the input register and rx_stall
// rises, while bytes giving no result keep flowing.
// Reset (rst, synchronous): hunting for the start byte, both registers
// empty, max_command back to 5.
module checksum_frame_receiver_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [2:0] event_res,
  output logic [7:0] command,
  output logic [7:0] payload_byte,
  output logic [7:0] payload_index,
  output logic [7:0] payload_length,
  output logic [7:0] computed_sum
);

  logic                  held_valid;
  logic [7:0]            held_byte;
  logic                  held_take;
  logic                  out_ready;
  cfr_pkg::result_beat_t beat;
  cfr_pkg::result_t      res;

  cfr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_byte    (rx_byte),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .held_take  (held_take)
  );

  cfr_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .held_take  (held_take),
    .out_ready  (out_ready),
    .beat       (beat)
  );

  cfr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .beat      (beat),
    .out_ready (out_ready),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  assign event_res      = res.ev;
  assign command        = res.command;
  assign payload_byte   = res.payload_byte;
  assign payload_index  = res.payload_index;
  assign payload_length = res.payload_length;
  assign computed_sum   = res.computed_sum;

endmodule
